// File: src/bcm_pkg.sv
// shared function codes for the bcm led row driver
package bcm_pkg;

  typedef enum logic [2:0] {
    FUNC_MOD_TICK  = 3'd0,
    FUNC_RAMP_TICK = 3'd1,
    FUNC_SET_LEVEL = 3'd2,
    FUNC_SET_COL   = 3'd3,
    FUNC_RAMP_START = 3'd4
  } func_e;

  localparam logic [7:0] WeightReset = 8'b1000_0000;
  localparam logic [7:0] ColIdle     = 8'hff;

endpackage

// File: src/bcm_led_row_driver_with_ramp_top.sv
// top level of the bcm led row driver with brightness ramp
//
// One input channel (in_valid_i / in_ready_o) carries a command word: a
// modulation tick, a ramp tick, a level write to a set of rows, a column
// select, or a ramp start. One output channel (out_valid_o / out_ready_i)
// returns one result word per command: the row drive pattern for the
// current bit weight, the active-low column lines and the ramp busy flag,
// all taken after the command has updated the state.
// The result of a word accepted at an edge is registered, valid after that
// edge. Throughput is one word per cycle unless the receiver stalls; the
// state update and result logic sit between handshake and result register.
// When the receiver stalls, the result register holds its word and a new
// command is taken in the same cycle that the held word is taken.
// Reset clears all levels, the column select and the ramp, sets the bit
// weight to the top bit and empties the result register.
module bcm_led_row_driver_with_ramp_top
  import bcm_pkg::*;
#(
  parameter int ROW_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  row_mask_i,
  input  logic [7:0]  level_i,
  input  logic [3:0]  column_i,
  input  logic [15:0] ramp_delay_i,
  input  logic [7:0]  ramp_top_i,
  input  logic        ramp_up_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  row_drive_o,
  output logic [7:0]  col_drive_o,
  output logic        ramp_busy_o
);

  logic [7:0]  row_level_q [ROW_COUNT];
  logic [7:0]  row_level_d [ROW_COUNT];
  logic [7:0]  bit_weight_q, bit_weight_d;
  logic [7:0]  weight_count_q, weight_count_d;
  logic [3:0]  column_select_q, column_select_d;
  logic [15:0] ramp_count_q, ramp_count_d;
  logic [7:0]  ramp_level_q, ramp_level_d;
  logic [7:0]  ramp_target_q, ramp_target_d;
  logic [15:0] ramp_period_q, ramp_period_d;
  logic [7:0]  ramp_rows_q, ramp_rows_d;
  logic        ramp_rising_q, ramp_rising_d;
  logic        ramp_running_q, ramp_running_d;

  logic        out_valid_q;
  logic [7:0]  row_drive_q, row_drive_d;
  logic [7:0]  col_drive_q, col_drive_d;
  logic        ramp_busy_q;

  logic        accept;
  logic        wr_en;
  logic [7:0]  wr_mask;
  logic [7:0]  wr_val;
  logic [7:0]  count_inc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign count_inc  = weight_count_q + 8'd1;

  always_comb begin
    bit_weight_d    = bit_weight_q;
    weight_count_d  = weight_count_q;
    column_select_d = column_select_q;
    ramp_count_d    = ramp_count_q;
    ramp_level_d    = ramp_level_q;
    ramp_target_d   = ramp_target_q;
    ramp_period_d   = ramp_period_q;
    ramp_rows_d     = ramp_rows_q;
    ramp_rising_d   = ramp_rising_q;
    ramp_running_d  = ramp_running_q;
    wr_en   = 1'b0;
    wr_mask = row_mask_i;
    wr_val  = level_i;
    unique case (func_i)
      FUNC_MOD_TICK: begin
        if (count_inc >= bit_weight_q) begin
          bit_weight_d   = {bit_weight_q[6:0], bit_weight_q[7]};
          weight_count_d = 8'd0;
        end else begin
          weight_count_d = count_inc;
        end
      end
      FUNC_RAMP_TICK: begin
        if (ramp_running_q) begin
          if (ramp_count_q >= ramp_period_q) begin
            ramp_count_d = 16'd0;
            wr_mask      = ramp_rows_q;
            if (ramp_rising_q) begin
              if ({1'b0, ramp_level_q} + 9'd1 < {1'b0, ramp_target_q}) begin
                ramp_level_d = ramp_level_q + 8'd1;
                wr_en        = 1'b1;
                wr_val       = ramp_level_q + 8'd1;
              end else begin
                ramp_running_d = 1'b0;
              end
            end else begin
              wr_en = 1'b1;
              if (ramp_level_q > 8'd1) begin
                ramp_level_d = ramp_level_q - 8'd1;
                wr_val       = ramp_level_q - 8'd1;
              end else begin
                ramp_level_d   = 8'd0;
                wr_val         = 8'd0;
                ramp_running_d = 1'b0;
              end
            end
          end else begin
            ramp_count_d = ramp_count_q + 16'd1;
          end
        end
      end
      FUNC_SET_LEVEL: begin
        wr_en = 1'b1;
      end
      FUNC_SET_COL: begin
        column_select_d = column_i;
      end
      FUNC_RAMP_START: begin
        ramp_rows_d   = row_mask_i;
        ramp_period_d = ramp_delay_i;
        ramp_target_d = ramp_top_i;
        ramp_rising_d = ramp_up_i;
        ramp_count_d  = 16'd0;
        if (ramp_up_i) begin
          ramp_level_d   = 8'd0;
          wr_val         = 8'd0;
          wr_en          = (ramp_top_i != 8'd0);
          ramp_running_d = (ramp_top_i != 8'd0);
        end else begin
          ramp_level_d   = ramp_top_i;
          wr_val         = ramp_top_i;
          wr_en          = 1'b1;
          ramp_running_d = (ramp_top_i != 8'd0);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    row_drive_d = 8'd0;
    for (int r = 0; r < ROW_COUNT; r++) begin
      row_level_d[r] = (wr_en && wr_mask[r]) ? wr_val : row_level_q[r];
      row_drive_d[r] = |(row_level_d[r] & bit_weight_d);
    end
    if (column_select_d[3]) begin
      col_drive_d = ColIdle;
    end else begin
      col_drive_d = ~(8'd1 << column_select_d[2:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        row_level_q[r] <= 8'd0;
      end
      bit_weight_q    <= WeightReset;
      weight_count_q  <= 8'd0;
      column_select_q <= 4'd0;
      ramp_count_q    <= 16'd0;
      ramp_level_q    <= 8'd0;
      ramp_target_q   <= 8'd0;
      ramp_period_q   <= 16'd0;
      ramp_rows_q     <= 8'd0;
      ramp_rising_q   <= 1'b0;
      ramp_running_q  <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (accept) begin
        for (int r = 0; r < ROW_COUNT; r++) begin
          row_level_q[r] <= row_level_d[r];
        end
        bit_weight_q    <= bit_weight_d;
        weight_count_q  <= weight_count_d;
        column_select_q <= column_select_d;
        ramp_count_q    <= ramp_count_d;
        ramp_level_q    <= ramp_level_d;
        ramp_target_q   <= ramp_target_d;
        ramp_period_q   <= ramp_period_d;
        ramp_rows_q     <= ramp_rows_d;
        ramp_rising_q   <= ramp_rising_d;
        ramp_running_q  <= ramp_running_d;
        out_valid_q     <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_drive_q <= row_drive_d;
      col_drive_q <= col_drive_d;
      ramp_busy_q <= ramp_running_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_drive_o = row_drive_q;
  assign col_drive_o = col_drive_q;
  assign ramp_busy_o = ramp_busy_q;

  // weight stays one-hot and the counter stays below it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(bit_weight_q) && (weight_count_q < bit_weight_q))
    else $error("bit weight or weight counter out of range");

  // idle ramp keeps its tick counter cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ramp_running_q |-> (ramp_count_q == 16'd0))
    else $error("ramp counter moved while idle");

  // tick counter never passes the step period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_count_q <= ramp_period_q)
    else $error("ramp counter past period");

  // a held word is not replaced while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !accept)
    else $error("word taken while result register is full");

endmodule
